[src/lqm_pkg.sv]
// shared types and constants for the linked queue manager
`default_nettype none

package lqm_pkg;

    localparam int ENTRY_W        = 5;
    localparam int MODE_W         = 3;
    localparam int QID_W          = 3;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 8;
    localparam int POOL_SIZE_DEF  = 32;
    localparam int NUM_QUEUES_DEF = 8;

    // operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_WR_A,
        ST_WR_B,
        ST_DONE
    } seq_state_t;

    // per-field write enables of the link memory
    typedef struct packed {
        logic nxt;
        logic prv;
        logic more;
    } link_we_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] index;
        logic               valid;
        logic               empty;
    } result_t;

endpackage

`default_nettype wire

[src/lqm_link_mem.sv]
// pool link memory: next, prev and free-list continuation per entry
`default_nettype none

module lqm_link_mem #(
    parameter int POOL_SIZE = lqm_pkg::POOL_SIZE_DEF
) (
    input  wire                           aclk,
    input  lqm_pkg::link_we_t             we,
    input  wire [$clog2(POOL_SIZE)-1:0]   waddr,
    input  wire [$clog2(POOL_SIZE)-1:0]   wnext,
    input  wire [$clog2(POOL_SIZE)-1:0]   wprev,
    input  wire                           wmore,
    input  wire [$clog2(POOL_SIZE)-1:0]   raddr,
    output logic [$clog2(POOL_SIZE)-1:0]  rnext,
    output logic                          rmore
);
    import lqm_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);

    logic [AW-1:0] next_mem [POOL_SIZE];
    logic [AW-1:0] prev_mem [POOL_SIZE];
    logic          more_mem [POOL_SIZE];

    always_ff @(posedge aclk) begin
        if (we.nxt) begin
            next_mem[waddr] <= wnext;
        end
        if (we.prv) begin
            prev_mem[waddr] <= wprev;
        end
        if (we.more) begin
            more_mem[waddr] <= wmore;
        end
    end

    always_ff @(posedge aclk) begin
        rnext <= next_mem[raddr];
        rmore <= more_mem[raddr];
    end

endmodule

`default_nettype wire

[src/lqm_tail_mem.sv]
// queue tail pointer memory
`default_nettype none

module lqm_tail_mem #(
    parameter int POOL_SIZE  = lqm_pkg::POOL_SIZE_DEF,
    parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
    input  wire                                                    aclk,
    input  wire                                                    we,
    input  wire [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] waddr,
    input  wire [$clog2(POOL_SIZE)-1:0]                            wdata,
    input  wire [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] raddr,
    output logic [$clog2(POOL_SIZE)-1:0]                           rdata
);
    import lqm_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);

    logic [AW-1:0] tail_mem [NUM_QUEUES];

    always_ff @(posedge aclk) begin
        if (we) begin
            tail_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= tail_mem[raddr];
    end

endmodule

`default_nettype wire

[src/lqm_seq.sv]
// operation sequencer: free-list head, queue occupancy and link updates
`default_nettype none

module lqm_seq #(
    parameter int POOL_SIZE  = lqm_pkg::POOL_SIZE_DEF,
    parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
    input  wire                                                     aclk,
    input  wire                                                     aresetn,
    input  wire                                                     in_valid,
    input  wire [lqm_pkg::MODE_W-1:0]                               in_mode,
    input  wire [lqm_pkg::QID_W-1:0]                                in_queue_id,
    input  wire [lqm_pkg::ENTRY_W-1:0]                              in_entry_index,
    output logic                                                    in_ready,
    input  wire                                                     out_free,
    output logic                                                    out_valid,
    output lqm_pkg::result_t                                        out_res,
    output lqm_pkg::link_we_t                                       l_we,
    output logic [$clog2(POOL_SIZE)-1:0]                            l_waddr,
    output logic [$clog2(POOL_SIZE)-1:0]                            l_wnext,
    output logic [$clog2(POOL_SIZE)-1:0]                            l_wprev,
    output logic                                                    l_wmore,
    output logic [$clog2(POOL_SIZE)-1:0]                            l_raddr,
    input  wire [$clog2(POOL_SIZE)-1:0]                             l_rnext,
    input  wire                                                     l_rmore,
    output logic                                                    t_we,
    output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0]  t_waddr,
    output logic [$clog2(POOL_SIZE)-1:0]                            t_wdata,
    output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0]  t_raddr,
    input  wire [$clog2(POOL_SIZE)-1:0]                             t_rdata
);
    import lqm_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    seq_state_t state_reg, state_next;

    logic [AW-1:0]         clr_cnt_reg;
    logic                  clr_last;
    logic [AW-1:0]         free_head_reg, free_head_next;
    logic                  free_nonempty_reg, free_nonempty_next;
    logic [NUM_QUEUES-1:0] ne_reg;
    logic                  ne_set, ne_clr;

    logic [MODE_W-1:0]  mode_reg;
    logic [QW-1:0]      q_idx_reg;
    logic [AW-1:0]      e_idx_reg;
    logic               q_ok_reg, e_ok_reg;
    logic [AW-1:0]      t_reg, h_reg, h_next, n_reg;
    logic [ENTRY_W-1:0] res_index_reg, res_index_next;
    logic               res_valid_reg, res_valid_next;

    logic accept;
    logic ne_cur;

    assign accept   = in_valid && in_ready;
    assign clr_last = (clr_cnt_reg == AW'(POOL_SIZE - 1));
    assign ne_cur   = q_ok_reg && ne_reg[q_idx_reg];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1: begin
                state_next = ST_DONE;
                if ((mode_reg == MODE_INSERT && e_ok_reg && ne_cur) ||
                    (mode_reg == MODE_REMOVE && ne_cur) ||
                    (mode_reg == MODE_PEEK && ne_cur)) begin
                    state_next = ST_RD2;
                end
            end
            ST_RD2: begin
                state_next = ST_DONE;
                if (mode_reg == MODE_INSERT) begin
                    state_next = ST_WR_A;
                end else if (mode_reg == MODE_REMOVE && l_rnext != t_reg) begin
                    state_next = ST_RD3;
                end
            end
            ST_RD3:  state_next = ST_WR_A;
            ST_WR_A: state_next = ST_WR_B;
            ST_WR_B: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs and memory accesses
    always_comb begin
        in_ready           = 1'b0;
        out_valid          = 1'b0;
        l_we               = '0;
        l_waddr            = e_idx_reg;
        l_wnext            = '0;
        l_wprev            = '0;
        l_wmore            = 1'b0;
        l_raddr            = free_head_reg;
        t_we               = 1'b0;
        t_waddr            = q_idx_reg;
        t_wdata            = e_idx_reg;
        t_raddr            = QW'(in_queue_id);
        free_head_next     = free_head_reg;
        free_nonempty_next = free_nonempty_reg;
        ne_set             = 1'b0;
        ne_clr             = 1'b0;
        h_next             = h_reg;
        res_index_next     = res_index_reg;
        res_valid_next     = res_valid_reg;
        case (state_reg)
            ST_CLEAR: begin
                // rebuild the initial free chain, one entry a cycle
                l_we    = '{nxt: 1'b1, prv: 1'b1, more: 1'b1};
                l_waddr = clr_cnt_reg;
                l_wnext = clr_last ? '0 : clr_cnt_reg + AW'(1);
                l_wmore = !clr_last;
            end
            ST_IDLE: begin
                in_ready       = 1'b1;
                res_index_next = '0;
                res_valid_next = 1'b0;
            end
            ST_RD1: begin
                l_raddr = t_rdata;
                case (mode_reg)
                    MODE_ALLOC: begin
                        if (free_nonempty_reg) begin
                            l_we               = '{nxt: 1'b1, prv: 1'b1, more: 1'b1};
                            l_waddr            = free_head_reg;
                            free_head_next     = l_rnext;
                            free_nonempty_next = l_rmore;
                            res_index_next     = ENTRY_W'(free_head_reg);
                            res_valid_next     = 1'b1;
                        end
                    end
                    MODE_FREE: begin
                        if (e_ok_reg) begin
                            l_we               = '{nxt: 1'b1, prv: 1'b0, more: 1'b1};
                            l_wnext            = free_head_reg;
                            l_wmore            = free_nonempty_reg;
                            free_head_next     = e_idx_reg;
                            free_nonempty_next = 1'b1;
                        end
                    end
                    MODE_INSERT: begin
                        // first entry of an empty queue links to itself
                        if (q_ok_reg && e_ok_reg && !ne_cur) begin
                            l_we    = '{nxt: 1'b1, prv: 1'b1, more: 1'b0};
                            l_wnext = e_idx_reg;
                            l_wprev = e_idx_reg;
                            t_we    = 1'b1;
                            ne_set  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RD2: begin
                l_raddr = l_rnext;
                h_next  = l_rnext;
                case (mode_reg)
                    MODE_INSERT: begin
                        l_we    = '{nxt: 1'b1, prv: 1'b1, more: 1'b0};
                        l_wnext = l_rnext;
                        l_wprev = t_reg;
                        t_we    = 1'b1;
                    end
                    MODE_REMOVE: begin
                        res_index_next = ENTRY_W'(l_rnext);
                        res_valid_next = 1'b1;
                        if (l_rnext == t_reg) begin
                            l_we    = '{nxt: 1'b1, prv: 1'b1, more: 1'b0};
                            l_waddr = l_rnext;
                            ne_clr  = 1'b1;
                        end
                    end
                    default: begin
                        res_index_next = ENTRY_W'(l_rnext);
                        res_valid_next = 1'b1;
                    end
                endcase
            end
            ST_RD3: begin
                // tail skips over the removed head
                l_we    = '{nxt: 1'b1, prv: 1'b0, more: 1'b0};
                l_waddr = t_reg;
                l_wnext = l_rnext;
            end
            ST_WR_A: begin
                l_we = '{nxt: 1'b0, prv: 1'b1, more: 1'b0};
                if (mode_reg == MODE_INSERT) begin
                    l_waddr = h_reg;
                    l_wprev = e_idx_reg;
                end else begin
                    l_waddr = n_reg;
                    l_wprev = t_reg;
                end
            end
            ST_WR_B: begin
                if (mode_reg == MODE_INSERT) begin
                    l_we    = '{nxt: 1'b1, prv: 1'b0, more: 1'b0};
                    l_waddr = t_reg;
                    l_wnext = e_idx_reg;
                end else begin
                    l_we    = '{nxt: 1'b1, prv: 1'b1, more: 1'b0};
                    l_waddr = h_reg;
                end
            end
            ST_DONE: begin
                out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_res = '{index: res_index_reg, valid: res_valid_reg, empty: !ne_cur};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            free_head_reg     <= '0;
            free_nonempty_reg <= 1'b1;
            ne_reg            <= '0;
        end else begin
            state_reg         <= state_next;
            free_head_reg     <= free_head_next;
            free_nonempty_reg <= free_nonempty_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (ne_set) begin
                ne_reg[q_idx_reg] <= 1'b1;
            end else if (ne_clr) begin
                ne_reg[q_idx_reg] <= 1'b0;
            end
        end
    end

    // operation payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= in_mode;
            q_idx_reg <= QW'(in_queue_id);
            e_idx_reg <= AW'(in_entry_index);
            q_ok_reg  <= (32'(in_queue_id) < NUM_QUEUES);
            e_ok_reg  <= (32'(in_entry_index) < POOL_SIZE);
        end
        if (state_reg == ST_RD1) begin
            t_reg <= t_rdata;
        end
        if (state_reg == ST_RD3) begin
            n_reg <= l_rnext;
        end
        h_reg         <= h_next;
        res_index_reg <= res_index_next;
        res_valid_reg <= res_valid_next;
    end

    a_free_sets_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD1 && mode_reg == MODE_FREE && e_ok_reg)
        |=> (free_nonempty_reg && free_head_reg == $past(e_idx_reg)))
        else $error("free did not push the entry");

    a_alloc_empty_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD1 && mode_reg == MODE_ALLOC && !free_nonempty_reg)
        |=> ($stable(free_head_reg) && !free_nonempty_reg && !res_valid_reg))
        else $error("allocate changed an exhausted free list");

    a_last_remove_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD2 && mode_reg == MODE_REMOVE && l_rnext == t_reg)
        |=> !ne_reg[q_idx_reg])
        else $error("removing the only entry left the queue marked busy");

    a_valid_modes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && res_valid_reg)
        |-> (mode_reg == MODE_ALLOC || mode_reg == MODE_REMOVE || mode_reg == MODE_PEEK))
        else $error("entry reported for an operation without a result entry");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!in_ready && l_we.nxt))
        else $error("item taken during the clearing pass");

endmodule

`default_nettype wire

[src/linked_queue_manager_with_free_list.sv]
// top level of the linked queue manager with free list
// path from accept to m_tvalid: allocate, free, other modes and any item on an empty queue
//   pass RD1 and DONE; peek and last remove add RD2; insert behind a tail runs RD1, RD2, WR_A,
//   WR_B and DONE; remove runs RD1, RD2, RD3, WR_A, WR_B and DONE; DONE feeds the output register
// one item at a time: the next item is taken only after its result is registered
// after aresetn a clearing pass rebuilds the free chain with every entry and takes no item;
//   all queues come up empty
`default_nettype none

module linked_queue_manager_with_free_list #(
    parameter int POOL_SIZE  = lqm_pkg::POOL_SIZE_DEF,
    parameter int NUM_QUEUES = lqm_pkg::NUM_QUEUES_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // mode [2:0], queue_id [5:3], entry_index [10:6], zero [15:11]
    input  wire [lqm_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // result_index [4:0], result_valid [5], queue_empty [6], zero [7]
    output logic [lqm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lqm_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // input field unpacking
    logic [MODE_W-1:0]  in_mode;
    logic [QID_W-1:0]   in_queue_id;
    logic [ENTRY_W-1:0] in_entry_index;

    assign in_mode        = s_tdata[MODE_W-1:0];
    assign in_queue_id    = s_tdata[MODE_W+QID_W-1:MODE_W];
    assign in_entry_index = s_tdata[MODE_W+QID_W+ENTRY_W-1:MODE_W+QID_W];

    // sequencer to memory wiring
    link_we_t      l_we;
    logic [AW-1:0] l_waddr, l_wnext, l_wprev, l_raddr, l_rnext;
    logic          l_wmore, l_rmore;
    logic          t_we;
    logic [QW-1:0] t_waddr, t_raddr;
    logic [AW-1:0] t_wdata, t_rdata;

    // result handoff and output register
    logic    out_free, seq_out_valid;
    result_t seq_res;
    logic    m_tvalid_reg;
    result_t m_res_reg;

    // the output register frees as soon as its item is taken
    assign out_free = !m_tvalid_reg || m_tready;

    lqm_seq #(
        .POOL_SIZE  (POOL_SIZE),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_mode        (in_mode),
        .in_queue_id    (in_queue_id),
        .in_entry_index (in_entry_index),
        .in_ready       (s_tready),
        .out_free       (out_free),
        .out_valid      (seq_out_valid),
        .out_res        (seq_res),
        .l_we           (l_we),
        .l_waddr        (l_waddr),
        .l_wnext        (l_wnext),
        .l_wprev        (l_wprev),
        .l_wmore        (l_wmore),
        .l_raddr        (l_raddr),
        .l_rnext        (l_rnext),
        .l_rmore        (l_rmore),
        .t_we           (t_we),
        .t_waddr        (t_waddr),
        .t_wdata        (t_wdata),
        .t_raddr        (t_raddr),
        .t_rdata        (t_rdata)
    );

    // next/prev links and free-list continuation flags for every pool entry
    lqm_link_mem #(
        .POOL_SIZE (POOL_SIZE)
    ) u_link_mem (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wnext (l_wnext),
        .wprev (l_wprev),
        .wmore (l_wmore),
        .raddr (l_raddr),
        .rnext (l_rnext),
        .rmore (l_rmore)
    );

    // tail pointer of each queue, meaningful only while the queue is busy
    lqm_tail_mem #(
        .POOL_SIZE  (POOL_SIZE),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_tail_mem (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // output register: holds a finished item until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seq_out_valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_out_valid && out_free) begin
            m_res_reg <= seq_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg.empty, m_res_reg.valid, m_res_reg.index};

endmodule

`default_nettype wire

[bench/testbench.sv]
// self-checking testbench for the linked queue manager with free list
module testbench;
    import lqm_pkg::*;

    localparam int POOL        = POOL_SIZE_DEF;
    localparam int QUEUES      = NUM_QUEUES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MODE_MAX    = (1 << MODE_W) - 1;
    localparam logic [QID_W-1:0]   QID_MAX   = QID_W'(QUEUES - 1);
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = ENTRY_W'(POOL - 1);

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // chance in percent that a side idles on a given cycle
    int send_idle_pct = 13;
    int recv_idle_pct = 51;
    int mismatch_count = 0;
    int cycle_count = 0;

    // mirror of the pool: links, free chain and per-queue tails
    logic [ENTRY_W-1:0] link_next [POOL];
    logic [ENTRY_W-1:0] link_prev [POOL];
    logic               chain_more[POOL];
    logic [ENTRY_W-1:0] tail_of   [QUEUES];
    logic               busy_queue[QUEUES];
    logic [ENTRY_W-1:0] free_top;
    logic               free_avail;

    // results still owed by the block, oldest first
    result_t pending_results[$];
    // entries allocated or removed and not yet handed back
    logic [ENTRY_W-1:0] held_entries[$];

    linked_queue_manager_with_free_list u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // queue state just after reset: free chain runs 0, 1, ... last, all queues empty
    initial begin
        for (int i = 0; i < POOL; i++) begin
            link_next[i]  = (i + 1 < POOL) ? ENTRY_W'(i + 1) : '0;
            link_prev[i]  = '0;
            chain_more[i] = (i + 1 < POOL);
        end
        for (int i = 0; i < QUEUES; i++) begin
            tail_of[i]    = '0;
            busy_queue[i] = 1'b0;
        end
        free_top   = '0;
        free_avail = 1'b1;
    end

    // apply one operation to the mirror and return the result it should produce;
    // the link writes happen in the same order as in the block so that misuse
    // (an entry linked twice) ends up in the same state
    function automatic result_t apply_queue_op(input logic [MODE_W-1:0]  mode,
                                               input logic [QID_W-1:0]   qid,
                                               input logic [ENTRY_W-1:0] ent);
        result_t            r;
        logic [ENTRY_W-1:0] t;
        logic [ENTRY_W-1:0] h;
        logic [ENTRY_W-1:0] n;
        logic               q_ok;
        logic               e_ok;
        q_ok = (int'(qid) < QUEUES);
        e_ok = (int'(ent) < POOL);
        r = '0;
        case (mode)
            MODE_ALLOC: begin
                if (free_avail) begin
                    h             = free_top;
                    free_avail    = chain_more[h];
                    free_top      = link_next[h];
                    link_next[h]  = '0;
                    link_prev[h]  = '0;
                    chain_more[h] = 1'b0;
                    r.index       = h;
                    r.valid       = 1'b1;
                end
            end
            MODE_FREE: begin
                if (e_ok) begin
                    link_next[ent]  = free_top;
                    chain_more[ent] = free_avail;
                    free_top        = ent;
                    free_avail      = 1'b1;
                end
            end
            MODE_INSERT: begin
                if (q_ok && e_ok) begin
                    if (!busy_queue[qid]) begin
                        // first entry links to itself
                        link_next[ent]  = ent;
                        link_prev[ent]  = ent;
                        busy_queue[qid] = 1'b1;
                    end else begin
                        t              = tail_of[qid];
                        h              = link_next[t];
                        link_next[ent] = h;
                        link_prev[ent] = t;
                        link_prev[h]   = ent;
                        link_next[t]   = ent;
                    end
                    tail_of[qid] = ent;
                end
            end
            MODE_REMOVE: begin
                if (q_ok && busy_queue[qid]) begin
                    t = tail_of[qid];
                    h = link_next[t];
                    if (h == t) begin
                        busy_queue[qid] = 1'b0;
                    end else begin
                        n            = link_next[h];
                        link_next[t] = n;
                        link_prev[n] = t;
                    end
                    link_next[h] = '0;
                    link_prev[h] = '0;
                    r.index      = h;
                    r.valid      = 1'b1;
                end
            end
            MODE_PEEK: begin
                if (q_ok && busy_queue[qid]) begin
                    r.index = link_next[tail_of[qid]];
                    r.valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.empty = !(q_ok && busy_queue[qid]);
        return r;
    endfunction

    // compare each returned item with the oldest prediction
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, tdata %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[ENTRY_W-1:0] !== want.index) begin
                    $display("%0t: result_index expected %0d actual %0d",
                             $time, want.index, m_tdata[ENTRY_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[ENTRY_W] !== want.valid) begin
                    $display("%0t: result_valid expected %0b actual %0b",
                             $time, want.valid, m_tdata[ENTRY_W]);
                    mismatch_count++;
                end
                if (m_tdata[ENTRY_W+1] !== want.empty) begin
                    $display("%0t: queue_empty expected %0b actual %0b",
                             $time, want.empty, m_tdata[ENTRY_W+1]);
                    mismatch_count++;
                end
            end
        end
    end

    // present one item, hold it until taken, then record what it should return
    task automatic send_item(input logic [MODE_W-1:0]  mode,
                             input logic [QID_W-1:0]   qid,
                             input logic [ENTRY_W-1:0] ent,
                             output result_t           want);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({ent, qid, mode});
        do @(posedge aclk); while (!s_tready);
        want = apply_queue_op(mode, qid, ent);
        pending_results.push_back(want);
    endtask

    // stop sending until every owed result has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_queues();
        result_t r;
        send_item(MODE_PEEK, '0, '0, r);
        send_item(MODE_REMOVE, QID_MAX, ENTRY_MAX, r);
    endtask

    // three entries through the top queue: first insert, appends, peek, removals to empty
    task automatic test_fifo_order();
        result_t            r;
        logic [ENTRY_W-1:0] got[3];
        for (int i = 0; i < 3; i++) begin
            send_item(MODE_ALLOC, '0, '0, r);
            got[i] = r.index;
        end
        send_item(MODE_INSERT, QID_MAX, got[0], r);
        send_item(MODE_PEEK, QID_MAX, '0, r);
        send_item(MODE_INSERT, QID_MAX, got[1], r);
        send_item(MODE_INSERT, QID_MAX, got[2], r);
        send_item(MODE_PEEK, QID_MAX, ENTRY_MAX, r);
        repeat (4) send_item(MODE_REMOVE, QID_MAX, '0, r);
        for (int i = 2; i >= 0; i--) send_item(MODE_FREE, '0, got[i], r);
    endtask

    task automatic test_unknown_modes();
        result_t r;
        for (int m = int'(MODE_PEEK) + 1; m <= MODE_MAX; m++) begin
            send_item(MODE_W'(m), QID_MAX, ENTRY_MAX, r);
        end
    endtask

    task automatic test_alloc_free();
        result_t r;
        send_item(MODE_ALLOC, QID_MAX, ENTRY_MAX, r);
        send_item(MODE_FREE, QID_MAX, r.index, r);
    endtask

    // well-formed traffic: only held entries are inserted or freed; stretches that
    // fill the pool (down to exhaustion) alternate with stretches that drain it
    task automatic test_random_traffic(input int n_items);
        result_t            r;
        int                 done;
        int                 pick;
        int                 slot;
        int                 qspan;
        bit                 filling;
        logic [MODE_W-1:0]  mode;
        logic [QID_W-1:0]   qid;
        logic [ENTRY_W-1:0] ent;
        done = 0;
        filling = 1'b1;
        qspan = QUEUES - 1;
        while (done < n_items) begin
            if (done % 64 == 0) begin
                filling = !filling;
                // a narrow queue range lets a few queues grow deep
                qspan = $urandom_range(0, 1) ? 1 : QUEUES - 1;
            end
            pick = $urandom_range(0, 99);
            qid  = QID_W'($urandom_range(0, qspan));
            ent  = ENTRY_W'($urandom_range(0, POOL - 1));
            if (pick < 4) begin
                // ignored modes are noise and not counted
                mode = MODE_W'($urandom_range(int'(MODE_PEEK) + 1, MODE_MAX));
                send_item(mode, qid, ent, r);
                continue;
            end
            if (filling) begin
                mode = (pick < 45) ? MODE_ALLOC : (pick < 70) ? MODE_INSERT :
                       (pick < 80) ? MODE_REMOVE : (pick < 90) ? MODE_PEEK : MODE_FREE;
            end else begin
                mode = (pick < 14) ? MODE_ALLOC : (pick < 30) ? MODE_INSERT :
                       (pick < 65) ? MODE_REMOVE : (pick < 75) ? MODE_PEEK : MODE_FREE;
            end
            if ((mode == MODE_INSERT || mode == MODE_FREE) && held_entries.size() == 0) begin
                mode = MODE_ALLOC;
            end
            if (mode == MODE_INSERT || mode == MODE_FREE) begin
                slot = $urandom_range(0, held_entries.size() - 1);
                ent  = held_entries[slot];
                held_entries.delete(slot);
            end
            send_item(mode, qid, ent, r);
            if ((mode == MODE_ALLOC || mode == MODE_REMOVE) && r.valid) begin
                held_entries.push_back(r.index);
            end
            done++;
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 199) == 0) wait_all_results();
        end
    endtask

    // arbitrary items including double frees and re-inserts of linked entries;
    // run last since it may leave the lists tangled
    task automatic test_misuse_and_noise(input int n_items);
        result_t r;
        repeat (n_items) begin
            send_item(MODE_W'($urandom_range(0, MODE_MAX)),
                      QID_W'($urandom_range(0, QUEUES - 1)),
                      ENTRY_W'($urandom_range(0, POOL - 1)), r);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles lightly, receiver stalls about half the time
        test_empty_queues();
        test_fifo_order();
        test_unknown_modes();
        test_alloc_free();
        wait_all_results();
        test_random_traffic(590);
        wait_all_results();

        // sender idles heavily, receiver lightly
        send_idle_pct = 51;
        recv_idle_pct = 13;
        test_random_traffic(590);
        wait_all_results();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(590);
        test_misuse_and_noise(60);

        wait_all_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
